// ----- sv/luma_histogram_black_detect_defines.svh -----
// Assertion macros for the luma histogram block.
`ifndef LUMA_HISTOGRAM_BLACK_DETECT_DEFINES_SVH
`define LUMA_HISTOGRAM_BLACK_DETECT_DEFINES_SVH

`ifndef ASSERT_OFF
`define LHBD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define LHBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LHBD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define LHBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- sv/lhbd_pkg.sv -----
// Types and constants shared by the luma histogram block.
package lhbd_pkg;

  localparam int NUM_BINS    = 256;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int COUNT_WIDTH = 24;
  localparam int LIMIT_W     = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] LUMA_WR = 16'd77;
  localparam logic [15:0] LUMA_WG = 16'd150;
  localparam logic [15:0] LUMA_WB = 16'd29;

  localparam logic [LIMIT_W-1:0] DARK_LIMIT_RESET = LIMIT_W'(15);

  typedef enum logic [1:0] {
    MODE_ACC   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } back_state_t;

  // classified request: bin is the luma for accumulate, the bin index otherwise
  typedef struct packed {
    mode_t            mode;
    logic [BIN_W-1:0] bin;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic  avail;
    item_t item;
  } q_rd_t;

endpackage

// ----- sv/lhbd_if.sv -----
// Channel interfaces: pixel requests, results and the dark limit write port.
interface lhbd_pix_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] bin_index;
  modport source (output valid, mode, red, green, blue, bin_index, input ready);
  modport sink (input valid, mode, red, green, blue, bin_index, output ready);
endinterface

interface lhbd_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  luma;
  logic [23:0] bin_count;
  logic [23:0] max_count;
  logic [23:0] pixel_total;
  logic [23:0] dark_total;
  logic        is_black;
  modport source (output valid, luma, bin_count, max_count, pixel_total, dark_total,
                  is_black, input ready);
  modport sink (input valid, luma, bin_count, max_count, pixel_total, dark_total,
                is_black, output ready);
endinterface

interface lhbd_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] dark_bin_limit;
  modport source (output valid, dark_bin_limit, input ready);
  modport sink (input valid, dark_bin_limit, output ready);
endinterface

// ----- sv/lhbd_front.sv -----
// Front end: accepts pixel requests, computes luma and classifies them.
module lhbd_front (
  lhbd_pix_if.sink     pix,
  input  logic         q_full,
  output lhbd_pkg::q_wr_t q_wr
);
  import lhbd_pkg::*;

  logic [15:0] wsum;
  mode_t       mode;

  assign wsum = 16'(pix.red) * LUMA_WR + 16'(pix.green) * LUMA_WG
              + 16'(pix.blue) * LUMA_WB;
  assign mode = mode_t'(pix.mode);

  assign pix.ready = !q_full;

  always_comb begin
    q_wr.push      = pix.valid && !q_full;
    q_wr.item.mode = mode;
    q_wr.item.bin  = (mode == MODE_ACC) ? wsum[15:8] : pix.bin_index;
  end

endmodule

// ----- sv/lhbd_queue.sv -----
// Short request queue between front end and back end.
module lhbd_queue (
  input  logic            clk,
  input  logic            rst,
  input  lhbd_pkg::q_wr_t q_wr,
  input  logic            pop,
  output logic            full,
  output lhbd_pkg::q_rd_t q_rd
);
  import lhbd_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push = q_wr.push && !full;
  assign do_pop  = pop && (count != '0);

  assign q_rd.avail = (count != '0);
  assign q_rd.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/lhbd_back.sv -----
// Back end: bin memory read-modify-write, frame counters and result register.
`include "luma_histogram_black_detect_defines.svh"

module lhbd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [lhbd_pkg::LIMIT_W-1:0]   dark_bin_limit,
  input  lhbd_pkg::q_rd_t                q_rd,
  output logic                           pop,
  lhbd_res_if.source                     res
);
  import lhbd_pkg::*;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  function automatic count_t sat_inc(count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  back_state_t state;
  back_state_t state_next;

  count_t        mem [NUM_BINS];
  logic [NUM_BINS-1:0] bin_valid;
  count_t        rdata;
  logic          rvalid;
  item_t         cur;

  count_t peak_count;
  count_t pixel_count;
  count_t dark_count;
  count_t peak_next;
  count_t pixel_next;
  count_t dark_next;
  count_t c_inc;

  logic go;
  logic upd;
  logic mem_we;
  logic clear;
  logic res_valid;

  assign go     = !res_valid || res.ready;
  assign c_inc  = rvalid ? sat_inc(rdata) : count_t'(1);
  assign mem_we = upd && (cur.mode == MODE_ACC);
  assign clear  = upd && (cur.mode == MODE_CLEAR);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    upd        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_rd.avail) begin
          pop        = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          upd        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    peak_next  = peak_count;
    pixel_next = pixel_count;
    dark_next  = dark_count;
    case (cur.mode)
      MODE_ACC: begin
        peak_next  = (c_inc > peak_count) ? c_inc : peak_count;
        pixel_next = sat_inc(pixel_count);
        if ({1'b0, cur.bin} < dark_bin_limit) begin
          dark_next = sat_inc(dark_count);
        end
      end
      MODE_CLEAR: begin
        peak_next  = '0;
        pixel_next = '0;
        dark_next  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // bin memory: read on pop, write back on update
  always_ff @(posedge clk) begin
    if (pop) begin
      rdata <= mem[q_rd.item.bin];
      rvalid <= bin_valid[q_rd.item.bin];
      cur    <= q_rd.item;
    end
    if (mem_we) begin
      mem[cur.bin] <= c_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      bin_valid <= '0;
    end else if (mem_we) begin
      bin_valid[cur.bin] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_count  <= '0;
      pixel_count <= '0;
      dark_count  <= '0;
    end else if (upd) begin
      peak_count  <= peak_next;
      pixel_count <= pixel_next;
      dark_count  <= dark_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (upd) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      res.luma        <= (cur.mode == MODE_ACC) ? cur.bin : '0;
      res.bin_count   <= (cur.mode == MODE_READ && rvalid) ? rdata : '0;
      res.max_count   <= peak_next;
      res.pixel_total <= pixel_next;
      res.dark_total  <= dark_next;
      res.is_black    <= (dark_next >= (pixel_next >> 1));
    end
  end

  assign res.valid = res_valid;

  `LHBD_ASSERT_IMPLY(a_peak_le_pixels, clk, rst, 1'b1, peak_count <= pixel_count, "peak count above pixel count")
  `LHBD_ASSERT_IMPLY(a_dark_le_pixels, clk, rst, 1'b1, dark_count <= pixel_count, "dark count above pixel count")
  `LHBD_ASSERT_IMPLY(a_res_from_exec, clk, rst, $rose(res_valid), $past(state) == ST_EXEC, "result loaded outside execute")
  `LHBD_ASSERT_NEXT(a_pop_then_exec, clk, rst, pop, state == ST_EXEC, "pop did not start execute")

endmodule

// ----- sv/luma_histogram_black_detect.sv -----
// Luma histogram with black-frame detection: top level.
// A request passes through the queue, the bin memory read register and the result register.
// The back end pops the next request only after the read and write-back of the bin memory for the last.
// The front end keeps taking requests into a 2-entry queue, until it is full, while the back end works or stalls.
// Reset (rst, synchronous): clears queue, bin valid flags, counters, output valid,
// and sets the dark limit to 15; no clearing pass is needed.
module luma_histogram_black_detect (
  input  logic        clk,
  input  logic        rst,
  lhbd_pix_if.sink    pix,
  lhbd_cfg_if.sink    cfg,
  lhbd_res_if.source  res
);
  import lhbd_pkg::*;

  logic [LIMIT_W-1:0] dark_bin_limit;
  q_wr_t              q_wr;
  q_rd_t              q_rd;
  logic               q_full;
  logic               pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_bin_limit <= DARK_LIMIT_RESET;
    end else if (cfg.valid) begin
      dark_bin_limit <= cfg.dark_bin_limit;
    end
  end

  lhbd_front u_front (
    .pix    (pix),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  lhbd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .pop  (pop),
    .full (q_full),
    .q_rd (q_rd)
  );

  lhbd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .dark_bin_limit (dark_bin_limit),
    .q_rd           (q_rd),
    .pop            (pop),
    .res            (res)
  );

endmodule
